>>> hw/rtl/mkq_pkg.sv
// Shared types, constants and the character code table for the Morse keyer queue.
// No dependencies; imported by morse_keyer_queue, mkq_front, mkq_text_q and mkq_back.
package mkq_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] DIT_TICKS_RST  = 16'd61;
  localparam logic [15:0] DAH_TICKS_RST  = 16'd183;
  localparam logic [15:0] EGAP_TICKS_RST = 16'd61;
  localparam logic [15:0] LGAP_TICKS_RST = 16'd122;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_PUSH = 1'b1;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [5:0] DIGIT_BASE = 6'd26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIT  = 2'd0,
    CFG_DAH  = 2'd1,
    CFG_EGAP = 2'd2,
    CFG_LGAP = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] dit_ticks;
    logic [15:0] dah_ticks;
    logic [15:0] element_gap_ticks;
    logic [15:0] letter_gap_ticks;
  } cfg_regs_t;

  // len of zero marks a character without a code; dah bit i is element i
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] dah;
  } code_t;

  typedef struct packed {
    logic  is_push;
    code_t code;
  } cmd_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } tq_ctl_t;

  localparam code_t MORSE_TBL [36] = '{
    '{3'd2, 5'b00010}, '{3'd4, 5'b00001}, '{3'd4, 5'b00101}, '{3'd3, 5'b00001},
    '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b00011}, '{3'd4, 5'b00000},
    '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b00101}, '{3'd4, 5'b00010},
    '{3'd2, 5'b00011}, '{3'd2, 5'b00001}, '{3'd3, 5'b00111}, '{3'd4, 5'b00110},
    '{3'd4, 5'b01011}, '{3'd3, 5'b00010}, '{3'd3, 5'b00000}, '{3'd1, 5'b00001},
    '{3'd3, 5'b00100}, '{3'd4, 5'b01000}, '{3'd3, 5'b00110}, '{3'd4, 5'b01001},
    '{3'd4, 5'b01101}, '{3'd4, 5'b00011},
    '{3'd5, 5'b11111}, '{3'd5, 5'b11110}, '{3'd5, 5'b11100}, '{3'd5, 5'b11000},
    '{3'd5, 5'b10000}, '{3'd5, 5'b00000}, '{3'd5, 5'b00001}, '{3'd5, 5'b00011},
    '{3'd5, 5'b00111}, '{3'd5, 5'b01111}
  };

  function automatic code_t code_of(input logic [7:0] c);
    logic [7:0] idx;
    code_t      r;
    idx = 8'd0;
    r   = '{3'd0, 5'b00000};
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      idx = c - CH_LOWER_A;
      r   = MORSE_TBL[idx[5:0]];
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      idx = c - CH_UPPER_A;
      r   = MORSE_TBL[idx[5:0]];
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      idx = c - CH_ZERO;
      r   = MORSE_TBL[idx[5:0] + DIGIT_BASE];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/mkq_in_if.sv
// Input channel of the Morse keyer queue: valid/ready with command and character.
// Depends on nothing.
interface mkq_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_code;

  modport source (output valid, output cmd, output char_code, input ready);
  modport sink   (input valid, input cmd, input char_code, output ready);
endinterface

>>> hw/rtl/mkq_out_if.sv
// Result channel of the Morse keyer queue: valid/ready with keyer status flags.
// Depends on nothing.
interface mkq_out_if;
  logic valid;
  logic ready;
  logic tone_on;
  logic push_dropped;
  logic idle;

  modport source (output valid, output tone_on, output push_dropped, output idle, input ready);
  modport sink   (input valid, input tone_on, input push_dropped, input idle, output ready);
endinterface

>>> hw/rtl/morse_keyer_queue.sv
// Morse keyer with a character queue. Each input transaction is either a push of
// one character byte or one time tick, and each produces exactly one result
// (tone state, drop flag, idle flag). The block takes one transaction per clock
// whenever the result channel does not hold it back, and sustains that rate
// indefinitely: a tick does its element load, pop and countdown in the same
// cycle, and the text queue keeps its head code in a two-entry prefetch buffer
// in front of the registered-read RAM so a pop every clock never waits on the
// RAM read. An accepted transaction is held in the command queue, and the
// output register captures its result when the back end takes it. The user
// must write timing registers through the cfg port only while the block is
// idle; the block itself does not enforce this.
module morse_keyer_queue #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mkq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mkq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  mkq_in_if.sink                           in_ch,
  mkq_out_if.source                        out_ch
);
  import mkq_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  logic      cmd_valid;
  logic      cmd_ready;
  cmd_item_t cmd_item;
  tq_ctl_t   tq_ctl;
  code_t     tq_push_code;
  code_t     tq_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_DIT:  cfg_nxt.dit_ticks         = cfg_wdata;
        CFG_DAH:  cfg_nxt.dah_ticks         = cfg_wdata;
        CFG_EGAP: cfg_nxt.element_gap_ticks = cfg_wdata;
        CFG_LGAP: cfg_nxt.letter_gap_ticks  = cfg_wdata;
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dit_ticks         <= DIT_TICKS_RST;
      cfg_r.dah_ticks         <= DAH_TICKS_RST;
      cfg_r.element_gap_ticks <= EGAP_TICKS_RST;
      cfg_r.letter_gap_ticks  <= LGAP_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mkq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item)
  );

  mkq_text_q #(
    .DEPTH (QUEUE_DEPTH)
  ) u_text_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tq_ctl),
    .push_code (tq_push_code),
    .head      (tq_head)
  );

  mkq_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd_item     (cmd_item),
    .tq_ctl       (tq_ctl),
    .tq_push_code (tq_push_code),
    .tq_head      (tq_head),
    .out_ch       (out_ch)
  );

endmodule

>>> hw/rtl/mkq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mkq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mkq_front.sv
// Front end: accepts input transactions, classifies characters into Morse codes
// and holds them in a two-entry command queue. Depends on mkq_pkg and mkq_in_if.
module mkq_front (
  input  logic                  clk,
  input  logic                  rst_n,
  mkq_in_if.sink                in_ch,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output mkq_pkg::cmd_item_t    cmd_item
);
  import mkq_pkg::*;

  cmd_item_t  q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       enq, deq;
  cmd_item_t  new_item;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign enq         = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign deq         = cmd_valid && cmd_ready;
  assign cmd_item    = q_r[rd_r];

  always_comb begin
    new_item.is_push = (in_ch.cmd == CMD_PUSH);
    new_item.code    = code_of(in_ch.char_code);
    wr_nxt  = enq ? ~wr_r : wr_r;
    rd_nxt  = deq ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_r] <= new_item;
    end
  end

endmodule

>>> hw/rtl/mkq_text_q.sv
// Character queue: RAM storage plus a two-entry prefetch buffer so the head
// code is visible every cycle at one pop per clock. Depends on mkq_pkg, mkq_ram.
module mkq_text_q #(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mkq_pkg::tq_ctl_t     ctl,
  input  mkq_pkg::code_t       push_code,
  output mkq_pkg::code_t       head
);
  import mkq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] ram_cnt_r, ram_cnt_nxt;
  logic          rd_valid_r;
  code_t         pf_r [2];
  code_t         pf_nxt [2];
  logic [1:0]    pf_cnt_r, pf_cnt_nxt;
  logic [1:0]    vis_cnt;
  logic [1:0]    occ;
  logic [1:0]    total;
  logic          bypass;
  logic          ram_we;
  logic          issue;
  code_t         rd_code;
  code_t         lst0, lst1;

  assign vis_cnt = pf_cnt_r + {1'b0, rd_valid_r};
  assign bypass  = ctl.push && (ram_cnt_r == '0) && (vis_cnt < 2'd2);
  assign ram_we  = ctl.push && !bypass;
  assign occ     = vis_cnt - {1'b0, ctl.pop};
  assign issue   = (ram_cnt_r != '0) && (occ <= 2'd1);
  assign head    = (pf_cnt_r != 2'd0) ? pf_r[0] : rd_code;

  mkq_ram #(
    .WIDTH ($bits(code_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (push_code),
    .re    (issue),
    .raddr (rd_ptr_r),
    .rdata (rd_code)
  );

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (ram_we) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (issue) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    ram_cnt_nxt = ram_cnt_r + CW'(ram_we) - CW'(issue);

    // order: prefetch entries, landing read data, bypassed push
    lst0 = (pf_cnt_r != 2'd0) ? pf_r[0] : (rd_valid_r ? rd_code : push_code);
    if (pf_cnt_r == 2'd2) begin
      lst1 = pf_r[1];
    end else if (pf_cnt_r == 2'd1) begin
      lst1 = rd_valid_r ? rd_code : push_code;
    end else begin
      lst1 = push_code;
    end
    total = vis_cnt + {1'b0, bypass};
    if (ctl.pop) begin
      pf_nxt[0]  = lst1;
      pf_nxt[1]  = lst1;
      pf_cnt_nxt = total - 2'd1;
    end else begin
      pf_nxt[0]  = lst0;
      pf_nxt[1]  = lst1;
      pf_cnt_nxt = total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      ram_cnt_r  <= '0;
      rd_valid_r <= 1'b0;
      pf_cnt_r   <= 2'd0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      ram_cnt_r  <= ram_cnt_nxt;
      rd_valid_r <= issue;
      pf_cnt_r   <= pf_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pf_r[0] <= pf_nxt[0];
    pf_r[1] <= pf_nxt[1];
  end

endmodule

>>> hw/rtl/mkq_back.sv
// Back end: executes ticks and pushes, runs the element and gap countdowns and
// registers the result transaction. Depends on mkq_pkg and mkq_out_if.
module mkq_back #(
  parameter int DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mkq_pkg::cfg_regs_t    cfg,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  mkq_pkg::cmd_item_t    cmd_item,
  output mkq_pkg::tq_ctl_t      tq_ctl,
  output mkq_pkg::code_t        tq_push_code,
  input  mkq_pkg::code_t        tq_head,
  mkq_out_if.source             out_ch
);
  import mkq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]    elem_r, elem_nxt;
  logic [15:0]   tone_r, tone_nxt;
  logic [15:0]   sil_r, sil_nxt;
  logic          tstate_r, tstate_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          tone_on_r, dropped_r, idle_r;
  logic          take;
  logic          full;
  logic          dropped;
  logic          load;
  logic [7:0]    dah_ext;
  logic [15:0]   tone_ld, sil_ld;

  assign cmd_ready    = !out_valid_r || out_ch.ready;
  assign take         = cmd_valid && cmd_ready;
  assign full         = (count_r == CW'(DEPTH));
  assign tq_push_code = cmd_item.code;
  assign dah_ext      = {3'b000, tq_head.dah};

  always_comb begin
    tq_ctl.push = 1'b0;
    tq_ctl.pop  = 1'b0;
    dropped     = 1'b0;
    count_nxt   = count_r;
    elem_nxt    = elem_r;
    tone_ld     = tone_r;
    sil_ld      = sil_r;
    tone_nxt    = tone_r;
    sil_nxt     = sil_r;
    tstate_nxt  = tstate_r;
    load        = 1'b0;
    if (take) begin
      if (cmd_item.is_push) begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          tq_ctl.push = 1'b1;
          count_nxt   = count_r + 1'b1;
        end
      end else begin
        load = (tone_r == 16'd0) && (sil_r == 16'd0) && (count_r != '0);
        if (load) begin
          if (elem_r >= tq_head.len) begin
            tq_ctl.pop = 1'b1;
            count_nxt  = count_r - 1'b1;
            elem_nxt   = 3'd0;
            sil_ld     = cfg.letter_gap_ticks;
          end else begin
            tone_ld  = dah_ext[elem_r] ? cfg.dah_ticks : cfg.dit_ticks;
            sil_ld   = cfg.element_gap_ticks;
            elem_nxt = elem_r + 3'd1;
          end
        end
        if (tone_ld != 16'd0) begin
          tstate_nxt = 1'b1;
          tone_nxt   = tone_ld - 16'd1;
          sil_nxt    = sil_ld;
        end else if (sil_ld != 16'd0) begin
          tstate_nxt = 1'b0;
          tone_nxt   = tone_ld;
          sil_nxt    = sil_ld - 16'd1;
        end else begin
          tone_nxt = tone_ld;
          sil_nxt  = sil_ld;
        end
      end
    end
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      elem_r      <= 3'd0;
      tone_r      <= 16'd0;
      sil_r       <= 16'd0;
      tstate_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      elem_r      <= elem_nxt;
      tone_r      <= tone_nxt;
      sil_r       <= sil_nxt;
      tstate_r    <= tstate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tone_on_r <= tstate_nxt;
      dropped_r <= dropped;
      idle_r    <= (count_nxt == '0) && (tone_nxt == 16'd0) && (sil_nxt == 16'd0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tone_on      = tone_on_r;
  assign out_ch.push_dropped = dropped_r;
  assign out_ch.idle         = idle_r;

endmodule
